FILE: rtl/direction_frame_builder_assert.svh
// Assertion macros used by the checker file of the frame builder.
`ifndef DIRECTION_FRAME_BUILDER_ASSERT_SVH
`define DIRECTION_FRAME_BUILDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame builder check failed");

// Consequent must hold in the cycle after the antecedent.
`define DFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frame builder check failed");

`endif

FILE: rtl/dfb_pkg.sv
package dfb_pkg;

  localparam int FRAC_BITS = 16;
  // Quotient bits of every normalizing division; all quotients are at most 1.0.
  localparam int QB = FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(QB);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  localparam logic [30:0] DIAG_ONE = 31'd1 << FRAC_BITS;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_2D = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS = 1'b1;

  localparam logic [1:0] ROW_XLATE = 2'd3;

  typedef struct packed {
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic signed [31:0] dst_z;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic [30:0]        size_z;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col_x;
    logic signed [31:0] col_y;
    logic signed [31:0] col_z;
    logic [30:0]        scale_diag;
    logic               last;
  } out_req_t;

  // Classified item: direction as sign and magnitude, already scaled into 31 bits.
  typedef struct packed {
    logic [2:0][31:0] dst;
    logic [2:0][30:0] dm;
    logic [2:0]       dn;
    logic             shifted;
    logic [30:0]      size_x;
    logic [30:0]      size_y;
    logic [30:0]      size_z;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QB-1:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/dfb_front.sv
module dfb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dfb_pkg::in_req_t in_req_i,
  output logic             push_o,
  output dfb_pkg::job_t    job_o,
  input  logic             q_ready_i
);
  import dfb_pkg::*;

  logic          vld_q, vld_d;
  job_t          job_q, job_c;
  logic [2:0][31:0] src, dst;
  logic [2:0][32:0] diff, dmag;
  logic          big;

  always_comb begin
    src = {in_req_i.src_z, in_req_i.src_y, in_req_i.src_x};
    dst = {in_req_i.dst_z, in_req_i.dst_y, in_req_i.dst_x};
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {dst[i][31], dst[i]} - {src[i][31], src[i]};
      dmag[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
      big = big | dmag[i][32] | dmag[i][31];
    end
    // One halving always brings a 33-bit difference below 2^31.
    for (int i = 0; i < 3; i++) begin
      job_c.dm[i] = big ? dmag[i][31:1] : dmag[i][30:0];
      job_c.dn[i] = diff[i][32];
    end
    job_c.dst     = dst;
    job_c.shifted = big;
    job_c.size_x  = in_req_i.size_x;
    job_c.size_y  = in_req_i.size_y;
    job_c.size_z  = in_req_i.size_z;
  end

  assign in_ready_o = !vld_q || q_ready_i;
  assign push_o     = vld_q;
  assign job_o      = job_q;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (q_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      job_q <= job_c;
    end
  end

endmodule

FILE: rtl/dfb_fifo.sv
module dfb_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dfb_pkg::job_t wdata_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dfb_pkg::job_t rdata_o
);
  import dfb_pkg::*;

  job_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_push, do_pop;

  assign ready_o = cnt_q != (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/dfb_sqrt.sv
module dfb_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfb_pkg::sqrt_req_t req_i,
  output dfb_pkg::sqrt_rsp_t rsp_o
);
  import dfb_pkg::*;

  logic        busy_q, done_q;
  logic [63:0] n_q, r_q, b_q, trial;
  logic        ge;

  assign trial = r_q + b_q;
  assign ge    = n_q >= trial;
  assign rsp_o = '{done: done_q, root: r_q[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= !b_q[0];
      done_q <= b_q[0];
    end else begin
      done_q <= 1'b0;
    end
  end

  // One result bit per cycle, 32 root bits for a 64-bit radicand.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q <= req_i.rad;
      r_q <= '0;
      b_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (ge) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

endmodule

FILE: rtl/dfb_div.sv
module dfb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dfb_pkg::div_req_t req_i,
  output dfb_pkg::div_rsp_t rsp_o
);
  import dfb_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [31:0]          rem_q, den_q;
  logic [QB-1:0]        nb_q, q_q;
  logic [32:0]          t, tdiff;
  logic                 ge;

  assign t     = {rem_q, nb_q[QB-1]};
  assign tdiff = t - {1'b0, den_q};
  assign ge    = t >= {1'b0, den_q};
  assign rsp_o = '{done: done_q, quo: q_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(QB - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The quotient is known to fit in QB bits, so the high numerator part
  // starts out below the divisor and only QB restoring steps remain.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num[QB+31:QB];
      nb_q  <= req_i.num[QB-1:0];
      den_q <= req_i.den;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? tdiff[31:0] : t[31:0];
      q_q   <= {q_q[QB-2:0], ge};
      nb_q  <= nb_q << 1;
    end
  end

endmodule

FILE: rtl/dfb_back.sv
module dfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  dfb_pkg::job_t      job_i,
  output logic               job_pop_o,
  input  logic               mode_2d_i,
  input  logic [15:0]        eps_i,
  output dfb_pkg::sqrt_req_t sq_req_o,
  input  dfb_pkg::sqrt_rsp_t sq_rsp_i,
  output dfb_pkg::div_req_t  dv_req_o,
  input  dfb_pkg::div_rsp_t  dv_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dfb_pkg::out_req_t  out_req_o
);
  import dfb_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_DSQ   = 14'b00000000000010,
    ST_LEN   = 14'b00000000000100,
    ST_ADIV  = 14'b00000000001000,
    ST_VSEL  = 14'b00000000010000,
    ST_VSQ   = 14'b00000000100000,
    ST_VLEN  = 14'b00000001000000,
    ST_VDIV  = 14'b00000010000000,
    ST_CROSS = 14'b00000100000000,
    ST_WSQ   = 14'b00001000000000,
    ST_WLEN  = 14'b00010000000000,
    ST_WDIV  = 14'b00100000000000,
    ST_TRANS = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_e;

  state_e           st_q, st_d;
  logic [1:0]       k_q, k_d;
  logic             ph_q, ph_d;
  job_t             job_q;
  logic [63:0]      acc_q, acc_d, prod_q;
  logic signed [63:0] cr_q, cr_d;
  logic [31:0]      len_q, len_d;
  logic [2:0][31:0] am_q, am_d, vm_q, vm_d, wm_q, wm_d, t_q, t_d;
  logic [2:0]       an_q, an_d, vn_q, vn_d, wn_q, wn_d;

  logic [31:0]      mul_a, mul_b;
  logic             mul_neg;
  logic signed [63:0] sp, dw, rm, tt;
  logic [31:0]      eps32, dv_m;
  logic             vneg, load;

  out_req_t         rows_q [4];
  out_req_t         rows_d [4];
  out_req_t         row_a, row_v, row_w;
  logic [1:0]       row_q;
  logic             emit_q;

  function automatic logic [31:0] rnd_mag(input logic [63:0] m);
    logic [63:0] s;
    s = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return s[31:0];
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [31:0] to_s32(input logic n, input logic [31:0] m);
    return n ? (32'd0 - m) : m;
  endfunction

  assign eps32 = {16'd0, eps_i};

  // Operand select for the one shared multiplier; product registered.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (st_q)
      ST_DSQ: begin
        mul_a = {1'b0, job_q.dm[k_q]};
        mul_b = {1'b0, job_q.dm[k_q]};
      end
      ST_VSQ: begin
        mul_a = k_q[0] ? am_q[2] : am_q[1];
        mul_b = mul_a;
      end
      ST_CROSS: begin
        case (k_q)
          2'd0: begin
            mul_a = am_q[1]; mul_b = vm_q[2]; mul_neg = an_q[1] ^ vn_q[2];
          end
          2'd1: begin
            mul_a = am_q[2]; mul_b = vm_q[1]; mul_neg = an_q[2] ^ vn_q[1];
          end
          2'd2: begin
            mul_a = am_q[0]; mul_b = vm_q[2]; mul_neg = an_q[0] ^ vn_q[2];
          end
          default: begin
            mul_a = am_q[0]; mul_b = vm_q[1]; mul_neg = an_q[0] ^ vn_q[1];
          end
        endcase
      end
      ST_WSQ: begin
        mul_a = wm_q[k_q];
        mul_b = wm_q[k_q];
      end
      ST_TRANS: begin
        mul_a   = {1'b0, job_q.size_x};
        mul_b   = am_q[k_q];
        mul_neg = an_q[k_q];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign sp   = mul_neg ? -$signed(prod_q) : $signed(prod_q);
  assign dw   = cr_q - sp;
  assign rm   = $signed((prod_q + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1));
  assign tt   = $signed({{32{job_q.dst[k_q][31]}}, job_q.dst[k_q]})
              - (an_q[k_q] ? -rm : rm);
  assign vneg = (am_q[1] != '0) && (am_q[2] != '0) && (an_q[1] != an_q[2]);
  assign load = (st_q == ST_DONE) && (!emit_q || (out_ready_i && row_q == ROW_XLATE));

  always_comb begin
    dv_m = '0;
    unique case (st_q)
      ST_ADIV: dv_m = {1'b0, job_q.dm[k_q]};
      ST_VDIV: dv_m = k_q[0] ? am_q[1] : am_q[2];
      ST_WDIV: dv_m = wm_q[k_q];
      default: dv_m = '0;
    endcase
  end

  always_comb begin
    st_d      = st_q;
    k_d       = k_q;
    ph_d      = ph_q;
    acc_d     = acc_q;
    cr_d      = cr_q;
    len_d     = len_q;
    am_d      = am_q;
    an_d      = an_q;
    vm_d      = vm_q;
    vn_d      = vn_q;
    wm_d      = wm_q;
    wn_d      = wn_q;
    t_d       = t_q;
    job_pop_o = 1'b0;
    sq_req_o  = '0;
    dv_req_o  = '0;
    dv_req_o.num = ({32'd0, dv_m} << FRAC_BITS) + {33'd0, len_q[31:1]};
    dv_req_o.den = len_q;

    unique case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          st_d  = ST_DSQ;
          k_d   = '0;
          ph_d  = 1'b0;
          acc_d = '0;
        end
      end
      ST_DSQ, ST_VSQ, ST_WSQ: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d  = 1'b0;
          acc_d = acc_q + prod_q;
          if ((st_q == ST_VSQ && k_q == 2'd1) || (st_q != ST_VSQ && k_q == 2'd2)) begin
            sq_req_o.start = 1'b1;
            sq_req_o.rad   = acc_q + prod_q;
            st_d = (st_q == ST_DSQ) ? ST_LEN : ((st_q == ST_VSQ) ? ST_VLEN : ST_WLEN);
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (sq_rsp_i.done) begin
          len_d = sq_rsp_i.root;
          k_d   = '0;
          ph_d  = 1'b0;
          if (job_q.shifted || sq_rsp_i.root > eps32) begin
            st_d = ST_ADIV;
          end else begin
            for (int i = 0; i < 3; i++) begin
              am_d[i] = {1'b0, job_q.dm[i]};
            end
            an_d = job_q.dn;
            st_d = ST_VSEL;
          end
        end
      end
      ST_ADIV, ST_VDIV, ST_WDIV: begin
        if (!ph_q) begin
          dv_req_o.start = 1'b1;
          ph_d = 1'b1;
        end else if (dv_rsp_i.done) begin
          ph_d = 1'b0;
          if (st_q == ST_ADIV) begin
            am_d[k_q] = 32'(dv_rsp_i.quo);
            an_d[k_q] = job_q.dn[k_q];
          end else if (st_q == ST_VDIV) begin
            vm_d[k_q + 2'd1] = 32'(dv_rsp_i.quo);
          end else begin
            wm_d[k_q] = 32'(dv_rsp_i.quo);
          end
          if (st_q == ST_VDIV && k_q == 2'd1) begin
            st_d = ST_CROSS;
            k_d  = '0;
          end else if (st_q != ST_VDIV && k_q == 2'd2) begin
            st_d = (st_q == ST_ADIV) ? ST_VSEL : ST_TRANS;
            k_d  = '0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_VSEL: begin
        vm_d[0] = '0;
        vn_d    = '0;
        k_d     = '0;
        ph_d    = 1'b0;
        if (am_q[2] < eps32) begin
          vm_d[1] = '0;
          vm_d[2] = ONE;
          st_d    = ST_CROSS;
        end else if (am_q[1] < eps32) begin
          vm_d[1] = ONE;
          vm_d[2] = '0;
          st_d    = ST_CROSS;
        end else begin
          acc_d = '0;
          st_d  = ST_VSQ;
        end
      end
      ST_VLEN: begin
        if (sq_rsp_i.done) begin
          k_d  = '0;
          ph_d = 1'b0;
          if (sq_rsp_i.root == '0) begin
            // Both components zero with a zero threshold.
            vm_d[1] = '0;
            vm_d[2] = ONE;
            st_d    = ST_CROSS;
          end else begin
            len_d   = sq_rsp_i.root;
            vn_d[1] = an_q[2] ^ vneg;
            vn_d[2] = !an_q[1] ^ vneg;
            st_d    = ST_VDIV;
          end
        end
      end
      ST_CROSS: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          case (k_q)
            2'd0: cr_d = sp;
            2'd1: begin
              wm_d[0] = rnd_mag(abs64(dw));
              wn_d[0] = dw[63];
            end
            2'd2: begin
              wm_d[1] = rnd_mag(prod_q);
              wn_d[1] = !mul_neg;
            end
            default: begin
              wm_d[2] = rnd_mag(prod_q);
              wn_d[2] = mul_neg;
            end
          endcase
          if (k_q == 2'd3) begin
            st_d  = ST_WSQ;
            k_d   = '0;
            acc_d = '0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_WLEN: begin
        if (sq_rsp_i.done) begin
          k_d  = '0;
          ph_d = 1'b0;
          if (sq_rsp_i.root > eps32) begin
            len_d = sq_rsp_i.root;
            st_d  = ST_WDIV;
          end else begin
            st_d = ST_TRANS;
          end
        end
      end
      ST_TRANS: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (tt > 64'sd2147483647) begin
            t_d[k_q] = 32'h7FFF_FFFF;
          end else if (tt < -64'sd2147483648) begin
            t_d[k_q] = 32'h8000_0000;
          end else begin
            t_d[k_q] = tt[31:0];
          end
          if (k_q == 2'd2) begin
            st_d = ST_DONE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (load) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Row assembly for the output buffer.
  always_comb begin
    row_a.row_index  = '0;
    row_a.col_x      = to_s32(an_q[0], am_q[0]);
    row_a.col_y      = to_s32(an_q[1], am_q[1]);
    row_a.col_z      = to_s32(an_q[2], am_q[2]);
    row_a.scale_diag = job_q.size_x;
    row_a.last       = 1'b0;
    row_v            = row_a;
    row_v.col_x      = to_s32(vn_q[0], vm_q[0]);
    row_v.col_y      = to_s32(vn_q[1], vm_q[1]);
    row_v.col_z      = to_s32(vn_q[2], vm_q[2]);
    row_w            = row_a;
    row_w.col_x      = to_s32(wn_q[0], wm_q[0]);
    row_w.col_y      = to_s32(wn_q[1], wm_q[1]);
    row_w.col_z      = to_s32(wn_q[2], wm_q[2]);
    if (mode_2d_i) begin
      rows_d[0] = row_a;
      rows_d[1] = row_w;
      rows_d[2] = row_v;
      rows_d[1].scale_diag = job_q.size_y;
      rows_d[2].scale_diag = job_q.size_z;
    end else begin
      rows_d[0] = row_w;
      rows_d[1] = row_v;
      rows_d[2] = row_a;
      rows_d[0].scale_diag = job_q.size_y;
      rows_d[1].scale_diag = job_q.size_z;
    end
    rows_d[1].row_index = 2'd1;
    rows_d[2].row_index = 2'd2;
    rows_d[3].row_index  = ROW_XLATE;
    rows_d[3].col_x      = t_q[0];
    rows_d[3].col_y      = t_q[1];
    rows_d[3].col_z      = t_q[2];
    rows_d[3].scale_diag = DIAG_ONE;
    rows_d[3].last       = 1'b1;
  end

  assign out_valid_o = emit_q;
  assign out_req_o   = rows_q[row_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      k_q    <= '0;
      ph_q   <= 1'b0;
      emit_q <= 1'b0;
      row_q  <= '0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      ph_q <= ph_d;
      if (load) begin
        emit_q <= 1'b1;
        row_q  <= '0;
      end else if (emit_q && out_ready_i) begin
        if (row_q == ROW_XLATE) begin
          emit_q <= 1'b0;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    prod_q <= mul_a * mul_b;
    acc_q  <= acc_d;
    cr_q   <= cr_d;
    len_q  <= len_d;
    am_q   <= am_d;
    an_q   <= an_d;
    vm_q   <= vm_d;
    vn_q   <= vn_d;
    wm_q   <= wm_d;
    wn_q   <= wn_d;
    t_q    <= t_d;
    if (load) begin
      rows_q <= rows_d;
    end
  end

endmodule

FILE: rtl/direction_frame_builder.sv
// An accepted request passes the front end and the queue, and its first row leaves
// once the back end has done the normalizations and divisions that it needs. The
// sequencer runs two or three 32-step square roots and up to eight divisions through
// one divider. Requests are taken while the back end is busy if the queue has room.
// The four rows of a request leave on consecutive cycles when the sink is ready.
// Reset (rst_ni low, asynchronous) empties all stages; mode_2d resets to 0, eps to 1.
module direction_frame_builder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dfb_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dfb_pkg::out_req_t               out_req_o,
  input  logic                            cfg_we_i,
  input  logic [dfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dfb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import dfb_pkg::*;

  // Configuration registers. They are to be written by the user only while the block is idle; not enforced here.
  logic        mode_2d_q;
  logic [15:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_2d_q <= 1'b0;
      eps_q     <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE_2D: mode_2d_q <= cfg_wdata_i[0];
        CFG_EPS:     eps_q     <= cfg_wdata_i;
      endcase
    end
  end

  // The front end takes a request, forms the direction and scales it so
  // every component fits in 31 bits, then hands it to a small queue.
  logic  push, q_ready, job_valid, job_pop;
  job_t  front_job, queue_job;

  dfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .job_o      (front_job),
    .q_ready_i  (q_ready)
  );

  // The queue lets new requests arrive while the back end is still busy.
  dfb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_job),
    .ready_o (q_ready),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .rdata_o (queue_job)
  );

  // Shared iterative units used by the back-end sequencer.
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;
  div_req_t  dv_req;
  div_rsp_t  dv_rsp;

  dfb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  dfb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dv_req),
    .rsp_o  (dv_rsp)
  );

  // The back end builds the direction, the perpendicular, their cross
  // product and the translation, then fills a four-row output buffer. The
  // next request is processed while the buffer drains.
  dfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (queue_job),
    .job_pop_o   (job_pop),
    .mode_2d_i   (mode_2d_q),
    .eps_i       (eps_q),
    .sq_req_o    (sq_req),
    .sq_rsp_i    (sq_rsp),
    .dv_req_o    (dv_req),
    .dv_rsp_i    (dv_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

FILE: rtl/dfb_checker.sv
`include "direction_frame_builder_assert.svh"

module dfb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input dfb_pkg::out_req_t out_req_i
);
  import dfb_pkg::*;

  `DFB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_req_i))
  `DFB_ASSERT_NEXT(a_row_seq, clk_i, rst_ni, out_valid_i && out_ready_i && !out_req_i.last, out_valid_i && (out_req_i.row_index == $past(out_req_i.row_index) + 2'd1))
  `DFB_ASSERT_NOW(a_last_row, clk_i, rst_ni, out_valid_i, out_req_i.last == (out_req_i.row_index == ROW_XLATE))
  `DFB_ASSERT_NOW(a_xlate_diag, clk_i, rst_ni, out_valid_i && out_req_i.last, out_req_i.scale_diag == DIAG_ONE)

endmodule

bind direction_frame_builder dfb_checker u_dfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_i   (out_req_o)
);

FILE: bench/direction_frame_builder_checker.sv
// Watches both channels of the frame builder, predicts the four rows of every
// accepted request and compares them in order with the rows that leave.
module direction_frame_builder_checker
  import dfb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_req_t               in_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_req_t              out_req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    rows_pending_o,
  output int                    mismatches_o
);

  localparam longint ONE_L = longint'(1) << FRAC_BITS;

  logic              mode_2d_q;
  longint unsigned   eps_q;
  out_req_t          rows_due[$];

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(0) - x : x;
  endfunction

  function automatic longint with_sign(bit neg, longint unsigned m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint div_nearest(longint n, longint unsigned den);
    return with_sign(n < 0, (mag(n) + den / 2) / den);
  endfunction

  function automatic longint shift_nearest(longint x, int sh);
    return with_sign(x < 0, (mag(x) + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Direction, perpendicular and cross product, then the four rows in the
  // order that the current mode selects.
  task automatic build_frame_rows(input in_req_t r);
    longint          dst[3], dir[3], a[3], v[3], w[3], rows[3][3];
    longint unsigned s2, len, rad, nw;
    logic [30:0]     diag[3];
    bit              shifted, big, neg;
    out_req_t        o;
    dst[0] = longint'(r.dst_x);
    dst[1] = longint'(r.dst_y);
    dst[2] = longint'(r.dst_z);
    dir[0] = dst[0] - longint'(r.src_x);
    dir[1] = dst[1] - longint'(r.src_y);
    dir[2] = dst[2] - longint'(r.src_z);
    shifted = 0;
    // Differences beyond 31 bits are halved together until they fit.
    forever begin
      big = 0;
      for (int i = 0; i < 3; i++) if (mag(dir[i]) >= (64'd1 << 31)) big = 1;
      if (!big) break;
      shifted = 1;
      for (int i = 0; i < 3; i++) dir[i] = with_sign(dir[i] < 0, mag(dir[i]) >> 1);
    end
    s2 = 0;
    for (int i = 0; i < 3; i++) s2 += mag(dir[i]) * mag(dir[i]);
    len = int_sqrt(s2);
    for (int i = 0; i < 3; i++)
      a[i] = (shifted || len > eps_q) ? div_nearest(dir[i] * ONE_L, len) : dir[i];

    v[0] = 0;
    if (mag(a[2]) < eps_q) begin
      v[1] = 0;
      v[2] = ONE_L;
    end else if (mag(a[1]) < eps_q) begin
      v[1] = ONE_L;
      v[2] = 0;
    end else begin
      rad = int_sqrt(mag(a[1]) * mag(a[1]) + mag(a[2]) * mag(a[2]));
      if (rad == 0) begin
        v[1] = 0;
        v[2] = ONE_L;
      end else begin
        neg = (a[1] != 0) && (a[2] != 0) && ((a[1] < 0) != (a[2] < 0));
        v[1] = div_nearest(a[2] * ONE_L, rad);
        v[2] = div_nearest(-a[1] * ONE_L, rad);
        if (neg) begin
          v[1] = -v[1];
          v[2] = -v[2];
        end
      end
    end

    w[0] = shift_nearest(a[1] * v[2] - a[2] * v[1], FRAC_BITS);
    w[1] = shift_nearest(a[2] * v[0] - a[0] * v[2], FRAC_BITS);
    w[2] = shift_nearest(a[0] * v[1] - a[1] * v[0], FRAC_BITS);
    s2 = 0;
    for (int i = 0; i < 3; i++) s2 += mag(w[i]) * mag(w[i]);
    nw = int_sqrt(s2);
    if (nw > eps_q)
      for (int i = 0; i < 3; i++) w[i] = div_nearest(w[i] * ONE_L, nw);

    for (int i = 0; i < 3; i++) begin
      rows[0][i] = mode_2d_q ? a[i] : w[i];
      rows[1][i] = mode_2d_q ? w[i] : v[i];
      rows[2][i] = mode_2d_q ? v[i] : a[i];
    end
    diag[0] = mode_2d_q ? r.size_x : r.size_y;
    diag[1] = mode_2d_q ? r.size_y : r.size_z;
    diag[2] = mode_2d_q ? r.size_z : r.size_x;

    for (int k = 0; k < 4; k++) begin
      o.row_index = k[1:0];
      if (k < 3) begin
        o.col_x = clamp32(rows[k][0]);
        o.col_y = clamp32(rows[k][1]);
        o.col_z = clamp32(rows[k][2]);
        o.scale_diag = diag[k];
      end else begin
        o.col_x = clamp32(dst[0] - shift_nearest(longint'(r.size_x) * a[0], FRAC_BITS + 1));
        o.col_y = clamp32(dst[1] - shift_nearest(longint'(r.size_x) * a[1], FRAC_BITS + 1));
        o.col_z = clamp32(dst[2] - shift_nearest(longint'(r.size_x) * a[2], FRAC_BITS + 1));
        o.scale_diag = DIAG_ONE;
      end
      o.last = (k == 3);
      rows_due.push_back(o);
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  initial mismatches_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_2d_q <= 1'b0;
      eps_q = 1;
      rows_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) build_frame_rows(in_req_i);
      if (out_valid_i && out_ready_i) begin
        if (rows_due.size() == 0) begin
          $error("row %0d arrived with none expected", out_req_i.row_index);
          mismatches_o++;
        end else begin
          out_req_t want;
          want = rows_due.pop_front();
          check_field("row_index", want.row_index, out_req_i.row_index);
          check_field("col_x", want.col_x, out_req_i.col_x);
          check_field("col_y", want.col_y, out_req_i.col_y);
          check_field("col_z", want.col_z, out_req_i.col_z);
          check_field("scale_diag", want.scale_diag, out_req_i.scale_diag);
          check_field("last", want.last, out_req_i.last);
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE_2D) mode_2d_q <= cfg_wdata_i[0];
        else if (cfg_index_i == CFG_EPS) eps_q = cfg_wdata_i;
      end
    end
    rows_pending_o = rows_due.size();
  end

endmodule

FILE: bench/direction_frame_builder_test.sv
// Top of the frame builder bench. It makes the requests and register writes,
// randomizes both handshakes, and reports the verdict. All prediction and
// comparison is done by the checker that sits beside the block.
module direction_frame_builder_test;
  import dfb_pkg::*;

  // A quiet stretch on both channels that reaches HANG_LIMIT means the block has hung.
  localparam int HANG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_req_t              out_req;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE_2D;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    rows_pending;
  int                    mismatches;
  bit                    steady = 1'b0;   // When set, neither side idles.
  int                    quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  direction_frame_builder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  direction_frame_builder_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_req_i     (out_req),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .rows_pending_o(rows_pending),
    .mismatches_o  (mismatches)
  );

  // The sink stalls on about a fifth of the clocks unless the steady stretch is on.
  always @(negedge clk_i) out_ready <= steady || ($urandom_range(99) >= 20);

  // Hang detection: any accepted request or row restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("FAIL direction_frame_builder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request, with a random gap ahead of it, and holds it until
  // the block takes it.
  task automatic send_request(input in_req_t r);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_req = r;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Registers change only once every expected row has come out.
  task automatic set_frame_cfg(input logic mode, input logic [15:0] eps);
    @(negedge clk_i);
    in_valid = 1'b0;
    wait (rows_pending == 0);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_index = CFG_MODE_2D;
    cfg_wdata = {15'd0, mode};
    @(negedge clk_i);
    cfg_index = CFG_EPS;
    cfg_wdata = eps;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic in_req_t make_request(input logic signed [31:0] sx, sy, sz,
                                           input logic signed [31:0] dx, dy, dz,
                                           input logic [30:0] size_x);
    in_req_t r;
    r.src_x = sx;
    r.src_y = sy;
    r.src_z = sz;
    r.dst_x = dx;
    r.dst_y = dy;
    r.dst_z = dz;
    r.size_x = size_x;
    r.size_y = 31'($urandom());
    r.size_z = 31'($urandom());
    return r;
  endfunction

  function automatic logic signed [31:0] small_delta();
    return $signed($urandom_range(8192)) - 32'sd4096;
  endfunction

  // Half of the random requests are short directions near a random source, where the
  // normalization and the perpendicular choice matter; some zero one or two
  // axes, and the rest use fully random points.
  function automatic in_req_t random_request();
    in_req_t r;
    int kind;
    kind = int'($urandom_range(9));
    r = make_request($urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), 31'($urandom()));
    if (kind < 5) begin
      r.dst_x = r.src_x + (small_delta() <<< $urandom_range(12));
      r.dst_y = r.src_y + (small_delta() <<< $urandom_range(12));
      r.dst_z = r.src_z + (small_delta() <<< $urandom_range(12));
      r.size_x = 31'($urandom_range(32'h0040_0000));
    end else if (kind < 8) begin
      r.dst_x = r.src_x + small_delta();
      if ($urandom_range(1)) r.dst_y = r.src_y;
      else r.dst_y = r.src_y + ($urandom_range(3) == 0 ? 32'sd0 : small_delta());
      if ($urandom_range(1)) r.dst_z = r.src_z;
      else r.dst_z = r.src_z + small_delta();
    end
    return r;
  endfunction

  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic [30:0] SZ_MAX = 31'h7fff_ffff;

  task automatic directed_requests();
    // Zero direction stays unnormalized, and a tiny one below eps as well.
    send_request(make_request(0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(0, 0, 0, 1, 0, 0, 31'h10000));
    // Directions along each axis; the z axis picks a different perpendicular from x and y.
    send_request(make_request(0, 0, 0, 32'sh10000, 0, 0, 31'h20000));
    send_request(make_request(0, 0, 0, 0, 32'sh10000, 0, 31'h20000));
    send_request(make_request(0, 0, 0, 0, 0, -32'sh10000, 31'h20000));
    // General perpendicular with equal and opposite signs of y and z.
    send_request(make_request(0, 0, 0, 32'sh3000, 32'sh5000, 32'sh7000, 31'h18000));
    send_request(make_request(0, 0, 0, -32'sh3000, 32'sh5000, -32'sh7000, 31'h18000));
    // Differences beyond 31 bits force the halving; the last request has a zero direction.
    send_request(make_request(MINV, MINV, MINV, MAXV, MAXV, MAXV, SZ_MAX));
    send_request(make_request(MAXV, MINV, MAXV, MINV, MAXV, MINV, SZ_MAX));
    send_request(make_request(MAXV, 0, 0, MINV, 1, -1, 0));
    send_request(make_request(MINV, MAXV, MINV, MINV, MAXV, MINV, SZ_MAX));
  endtask

  task automatic eps_zero_requests();
    // With eps at zero: both y and z zero, then exactly one of them zero.
    send_request(make_request(0, 0, 0, 32'sh20000, 0, 0, 31'h10000));
    send_request(make_request(0, 0, 0, 32'sh20000, 0, 32'sh100, 31'h10000));
    send_request(make_request(0, 0, 0, 32'sh20000, -32'sh100, 0, 31'h10000));
    send_request(make_request(0, 0, 0, 0, 0, 1, 31'h10000));
    send_request(make_request(0, 0, 0, 0, 0, 0, SZ_MAX));
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    set_frame_cfg(1'b0, 16'd1);
    directed_requests();
    set_frame_cfg(1'b1, 16'd0);
    eps_zero_requests();
    directed_requests();
    set_frame_cfg(1'b0, 16'hffff);
    directed_requests();

    for (int phase = 0; phase < 6; phase++) begin
      set_frame_cfg(1'($urandom_range(1)),
                    (phase == 0) ? 16'd0 : (phase == 1) ? 16'hffff :
                    16'($urandom_range(16'hffff)));
      for (int n = 0; n < 24; n++) begin
        steady = (phase == 3);
        send_request(random_request());
      end
      steady = 1'b0;
    end

    @(negedge clk_i);
    in_valid = 1'b0;
    wait (rows_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS direction_frame_builder");
    end else begin
      $display("FAIL direction_frame_builder");
    end
    $finish;
  end

endmodule
